// ===== design/mbrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_pkg - shared types and constants of the modbus rtu response checker
// crc-16 step, status codes, register indexes and reset values
// ----------------------------------------------------------------------------
package mbrc_pkg;

   localparam int MAX_FRAME_DEFAULT = 256;
   localparam int MIN_FRAME         = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [8:0]  EXC_OFFSET = 9'd128;

   localparam logic [7:0] FUNC_READ_COILS = 8'd1;
   localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;

   localparam int          CSR_INDEX_W       = 1;
   localparam logic [0:0]  CSR_SLAVE_ID      = 1'b0;
   localparam logic [0:0]  CSR_FUNCTION_CODE = 1'b1;
   localparam logic [7:0]  SLAVE_ID_RESET    = 8'd1;
   localparam logic [7:0]  FUNCTION_RESET    = 8'd3;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_CRC_ERROR  = 3'd1,
      STATUS_ID_MISMATCH = 3'd2,
      STATUS_EXCEPTION  = 3'd3,
      STATUS_FUNC_MISMATCH = 3'd4,
      STATUS_TOO_SHORT  = 3'd5
   } status_type;

   // reflected crc-16 over one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== design/modbus_rtu_response_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker - byte-wise modbus rtu response check
// crc-16 over the frame minus its last two bytes, payload pass-through for
// read coils / read holding registers, and a status at frame end
// ----------------------------------------------------------------------------
//  channel  dir  handshake              content
//  req      in   req_tvalid/req_tready  tdata rx_byte, tlast frame_end
//  rsp      out  rsp_tvalid/rsp_tready  tdata payload/status, tuser payload_valid,
//                                       tlast frame_done
//  csr      in   csr_valid/csr_ready    csr_index, csr_data
//
//  one byte per cycle while req_tready is high; the frame state and the byte-wide
//  crc step update in the cycle a beat is accepted, and the result is registered
//  in the output register on that same accept
//  req_tready drops only while a result is held and rsp_tready is low
//  synchronous reset restores config, frame state, rsp_tvalid; csr always ready
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker #(
   parameter int MAX_FRAME = mbrc_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] rx_byte
   input  wire logic                          req_tlast,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [18:16] status,
   // [26:19] byte_count, [34:27] exception_code, [39:35] zero
   output      logic [39:0]                   rsp_tdata,
   output      logic                          rsp_tuser,   // [0] payload_valid
   output      logic                          rsp_tlast,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [mbrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                    csr_data
);

   localparam int POS_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = POS_W + 8;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 csr_fire;

   logic [7:0]           slave_id_ff;
   logic [7:0]           function_ff;

   logic [POS_W-1:0]     position_ff, position_in;
   logic [15:0]          crc_ff, crc_in;
   logic [15:0]          delay_ff, delay_in;
   logic [7:0]           rx_id_ff, rx_id_in;
   logic [7:0]           rx_func_ff, rx_func_in;
   logic [7:0]           count_ff, count_in;

   logic                 kept;
   logic [CMP_W-1:0]     k_ext;
   logic [CMP_W-1:0]     offset;
   logic                 func_read;
   logic                 pvalid;
   logic [7:0]           pbyte;
   logic [7:0]           pindex;
   logic [15:0]          msg_crc;
   mbrc_pkg::status_type status;
   logic [7:0]           exc_code;
   logic                 emit;

   logic                 rsp_valid_ff;
   logic                 rsp_pvalid_ff;
   logic                 rsp_last_ff;
   logic [7:0]           rsp_pbyte_ff;
   logic [7:0]           rsp_pindex_ff;
   mbrc_pkg::status_type rsp_status_ff;
   logic [7:0]           rsp_count_ff;
   logic [7:0]           rsp_exc_ff;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff <= mbrc_pkg::SLAVE_ID_RESET;
         function_ff <= mbrc_pkg::FUNCTION_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            mbrc_pkg::CSR_SLAVE_ID:      slave_id_ff <= csr_data;
            mbrc_pkg::CSR_FUNCTION_CODE: function_ff <= csr_data;
         endcase
      end
   end

   assign func_read = (function_ff == mbrc_pkg::FUNC_READ_COILS) ||
                      (function_ff == mbrc_pkg::FUNC_READ_HOLDING);
   assign kept      = position_ff < POS_W'(MAX_FRAME);
   assign k_ext     = CMP_W'(position_ff) - CMP_W'(2);
   assign offset    = k_ext - CMP_W'(3);

   // frame step for the current beat
   always_comb begin
      position_in = position_ff;
      crc_in      = crc_ff;
      delay_in    = delay_ff;
      rx_id_in    = rx_id_ff;
      rx_func_in  = rx_func_ff;
      count_in    = count_ff;
      pvalid      = 1'b0;
      pbyte       = '0;
      pindex      = '0;
      msg_crc     = delay_ff;
      if (kept) begin
         if (position_ff >= POS_W'(2)) begin
            crc_in = mbrc_pkg::crc_byte(crc_ff, delay_ff[15:8]);
            if (k_ext >= CMP_W'(3) && func_read && offset < CMP_W'(count_ff)) begin
               pvalid = 1'b1;
               pbyte  = delay_ff[15:8];
               pindex = offset[7:0];
            end
         end
         if (position_ff == POS_W'(0)) begin
            rx_id_in = req_tdata;
         end else if (position_ff == POS_W'(1)) begin
            rx_func_in = req_tdata;
         end else if (position_ff == POS_W'(2)) begin
            count_in = req_tdata;
         end
         msg_crc     = {delay_ff[7:0], req_tdata};
         delay_in    = {delay_ff[7:0], req_tdata};
         position_in = position_ff + POS_W'(1);
      end
   end

   // frame-end status
   always_comb begin
      status   = mbrc_pkg::STATUS_OK;
      exc_code = '0;
      if (req_tlast) begin
         priority if (position_in < POS_W'(mbrc_pkg::MIN_FRAME)) begin
            status = mbrc_pkg::STATUS_TOO_SHORT;
         end else if ({crc_in[7:0], crc_in[15:8]} != msg_crc) begin
            status = mbrc_pkg::STATUS_CRC_ERROR;
         end else if (rx_id_in != slave_id_ff) begin
            status = mbrc_pkg::STATUS_ID_MISMATCH;
         end else if ({1'b0, rx_func_in} == {1'b0, function_ff} + mbrc_pkg::EXC_OFFSET) begin
            status   = mbrc_pkg::STATUS_EXCEPTION;
            exc_code = count_in;
         end else if (rx_func_in != function_ff) begin
            status = mbrc_pkg::STATUS_FUNC_MISMATCH;
         end else begin
            status = mbrc_pkg::STATUS_OK;
         end
      end
   end

   assign emit = pvalid || req_tlast;

   // frame state
   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_tlast)) begin
         position_ff <= '0;
         crc_ff      <= mbrc_pkg::CRC_INIT;
         delay_ff    <= '0;
         rx_id_ff    <= '0;
         rx_func_ff  <= '0;
         count_ff    <= '0;
      end else if (req_fire) begin
         position_ff <= position_in;
         crc_ff      <= crc_in;
         delay_ff    <= delay_in;
         rx_id_ff    <= rx_id_in;
         rx_func_ff  <= rx_func_in;
         count_ff    <= count_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_pvalid_ff <= pvalid;
         rsp_last_ff   <= req_tlast;
         rsp_pbyte_ff  <= pbyte;
         rsp_pindex_ff <= pindex;
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
         rsp_exc_ff    <= exc_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_pvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_exc_ff, rsp_count_ff, 3'(rsp_status_ff),
                        rsp_pindex_ff, rsp_pbyte_ff};

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> position_ff == '0 && crc_ff == mbrc_pkg::CRC_INIT)
      else $error("frame state not cleared after frame end");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_W'(MAX_FRAME))
      else $error("position beyond frame limit");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("result with neither payload nor frame end");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_status_ff == mbrc_pkg::STATUS_OK)
      else $error("status reported before frame end");

   a_exc_only_on_exception: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status_ff != mbrc_pkg::STATUS_EXCEPTION |-> rsp_exc_ff == '0)
      else $error("exception code without exception status");

endmodule
`default_nettype wire
